/* src/dbec_pkg.sv */
package dbec_pkg;

    localparam int NCHAN    = 6;
    localparam int PIN_W    = 6;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 8;
    localparam int CODE_W   = 2;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_W    = 8;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 80;

    localparam int RELAY1_CH = 2;
    localparam int RELAY2_CH = 3;

    localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd30;
    localparam logic [CNT_W-1:0] INTERVAL_RESET = 8'd100;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 8'd1;

    typedef logic [CODE_W-1:0] t_code;

    localparam t_code CODE_IDLE = 2'd0;
    localparam t_code CODE_HELD = 2'd1;
    localparam t_code CODE_RISE = 2'd2;
    localparam t_code CODE_REL  = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE     = 4'b0001,
        PH_DEBOUNCE = 4'b0010,
        PH_RISING   = 4'b0100,
        PH_PRESSED  = 4'b1000
    } t_phase;

    typedef struct packed {
        logic             accept;
        logic             eval;
        logic [CNT_W-1:0] reload;
    } t_lane_ctl;

endpackage

/* src/six_input_debounce_edge_capture.sv */
// Six-input debounce with relay edge time capture.
// The slave stream takes one word per 10 ms tick: tdata carries the six
// active-low pin levels and the current seconds count. Every tick counts the
// channel timers and the sample-interval timer down; when the interval timer
// reaches zero all six channels are evaluated and one result word is sent on
// the master stream with six 2-bit codes and the two relay start times.
// Other ticks produce no word.
// A tick is accepted while the skid register is empty, so the block sustains
// one word per cycle unless the receiver stalls. The six channel machines work
// side by side, and a result word is registered when its tick is accepted.
// When the receiver stalls, one further result is held in a skid register
// and tready drops only while that register is full.
// After reset all channels are idle, all timers are zero, the start times
// are zero and the registers hold 30 and 100, so the first tick evaluates.
// The configuration channel is always ready; index 0 sets the debounce
// reload and index 1 sets the sample interval. Other indexes are ignored.
module six_input_debounce_edge_capture (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [5:0] pin_levels, [37:6] time_now, [39:38] zero
    input  logic [dbec_pkg::S_DATA_W-1:0]       i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [1:0] cap1_code, [3:2] cap2_code, [5:4] relay1_code, [7:6] relay2_code,
    // [9:8] fail1_code, [11:10] fail2_code, [43:12] relay1_start,
    // [75:44] relay2_start, [79:76] zero
    output logic [dbec_pkg::M_DATA_W-1:0]       o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [dbec_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [dbec_pkg::CFG_W-1:0]          i_cfg_data
);
    import dbec_pkg::*;

    logic [CNT_W-1:0]    r_debounce_ticks;
    logic [CNT_W-1:0]    r_sample_interval;
    logic [CNT_W-1:0]    r_interval;
    logic [CNT_W-1:0]    interval_dec;
    logic                accept;
    logic                eval;
    logic                push;
    logic                take;
    t_lane_ctl           ctl;
    t_code               codes [NCHAN];
    logic [PIN_W-1:0]    pins;
    logic [TIME_W-1:0]   time_now;
    logic [M_DATA_W-1:0] word;
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_skid_valid;
    logic [M_DATA_W-1:0] r_skid_data;

    assign pins     = i_s_tdata[PIN_W-1:0];
    assign time_now = i_s_tdata[PIN_W+TIME_W-1:PIN_W];

    assign o_s_tready = !r_skid_valid;
    assign accept     = i_s_tvalid && o_s_tready;
    assign interval_dec = (r_interval != '0) ? r_interval - CNT_W'(1) : r_interval;
    assign eval       = (interval_dec == '0);
    assign push       = accept && eval;

    assign ctl.accept = accept;
    assign ctl.eval   = eval;
    assign ctl.reload = r_debounce_ticks;

    genvar g;
    generate
        for (g = 0; g < NCHAN; g++) begin : g_lane
            dbec_lane u_lane (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_ctl    (ctl),
                .i_active (!pins[g]),
                .o_code   (codes[g])
            );
        end
    endgenerate

    dbec_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_codes (codes),
        .i_time  (time_now),
        .o_word  (word)
    );

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks  <= DEBOUNCE_RESET;
            r_sample_interval <= INTERVAL_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_DEBOUNCE: r_debounce_ticks  <= i_cfg_data;
                REG_INTERVAL: r_sample_interval <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= '0;
        end else if (accept) begin
            r_interval <= eval ? r_sample_interval : interval_dec;
        end
    end

    assign take       = r_out_valid && i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= push;
            end
        end else if (push) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || take) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
            end else if (push) begin
                r_out_data <= word;
            end
        end else if (push) begin
            r_skid_data <= word;
        end
    end

    a_skid_implies_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_interval_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && eval) |=> (r_interval == $past(r_sample_interval)))
        else $error("interval timer not reloaded after evaluation");

    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !r_out_valid) |=> o_m_tvalid)
        else $error("result of an evaluated tick not presented");

endmodule

/* src/dbec_lane.sv */
module dbec_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dbec_pkg::t_lane_ctl i_ctl,
    input  logic                i_active,
    output dbec_pkg::t_code     o_code
);
    import dbec_pkg::*;

    t_phase           r_phase;
    t_phase           n_phase;
    logic [CNT_W-1:0] r_cd;
    logic [CNT_W-1:0] n_cd;
    logic [CNT_W-1:0] cd_dec;
    logic             tz;

    assign cd_dec = (r_cd != '0) ? r_cd - CNT_W'(1) : r_cd;
    assign tz     = (cd_dec == '0);

    always_comb begin
        n_phase = r_phase;
        n_cd    = cd_dec;
        o_code  = CODE_IDLE;
        if (i_ctl.eval) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_active) begin
                        n_phase = PH_DEBOUNCE;
                        n_cd    = i_ctl.reload;
                    end
                end
                PH_DEBOUNCE: begin
                    if (i_active && tz) begin
                        n_phase = PH_RISING;
                        n_cd    = i_ctl.reload;
                    end
                end
                PH_RISING: begin
                    if (i_active && tz) begin
                        n_phase = PH_PRESSED;
                        o_code  = CODE_RISE;
                    end else if (!i_active) begin
                        n_phase = PH_IDLE;
                        o_code  = CODE_REL;
                    end
                end
                PH_PRESSED: begin
                    if (i_active && tz) begin
                        o_code  = CODE_HELD;
                    end else if (!i_active) begin
                        n_phase = PH_IDLE;
                        o_code  = CODE_REL;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cd    <= '0;
        end else if (i_ctl.accept) begin
            r_phase <= n_phase;
            r_cd    <= n_cd;
        end
    end

endmodule

/* src/dbec_merge.sv */
module dbec_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dbec_pkg::t_lane_ctl                 i_ctl,
    input  dbec_pkg::t_code                     i_codes [dbec_pkg::NCHAN],
    input  logic [dbec_pkg::TIME_W-1:0]         i_time,
    output logic [dbec_pkg::M_DATA_W-1:0]       o_word
);
    import dbec_pkg::*;

    logic [TIME_W-1:0] r_relay1_start;
    logic [TIME_W-1:0] r_relay2_start;
    logic [TIME_W-1:0] n_relay1_start;
    logic [TIME_W-1:0] n_relay2_start;

    assign n_relay1_start = (i_ctl.eval && i_codes[RELAY1_CH] == CODE_RISE) ?
                            i_time : r_relay1_start;
    assign n_relay2_start = (i_ctl.eval && i_codes[RELAY2_CH] == CODE_RISE) ?
                            i_time : r_relay2_start;

    assign o_word = {4'b0000, n_relay2_start, n_relay1_start,
                     i_codes[5], i_codes[4], i_codes[3],
                     i_codes[2], i_codes[1], i_codes[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_relay1_start <= '0;
            r_relay2_start <= '0;
        end else if (i_ctl.accept) begin
            r_relay1_start <= n_relay1_start;
            r_relay2_start <= n_relay2_start;
        end
    end

endmodule
